// ===== src/dbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbd_pkg - shared types and constants for the days-between-dates block
// Sequencer states, control word, month tables and arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dbd_pkg;

    // Sequencer steps; each date runs Y, Q, A, D, ACC once.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_Y,   // y * 1/100
        ST_MUL_Q,   // (y / 100) * 100, leap test operand
        ST_MUL_A,   // a * 1/100, date check
        ST_MUL_D,   // a * 365
        ST_ACC,     // accumulate day number
        ST_FIN      // clamp and register result
    } t_state;

    typedef struct packed {
        t_state state;
        logic   use_end;   // 0: start date, 1: end date
        logic   accept;    // new word taken this cycle
    } t_ctl;

    // floor(x / 100) == (x * 5243) >> 19 for x < 43690
    localparam logic [12:0] K_RECIP100  = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [12:0] K_HUNDRED   = 13'd100;
    localparam logic [12:0] K_YEAR_DAYS = 13'd365;
    localparam logic [14:0] K_EPOCH     = 15'd400;
    localparam logic [4:0]  K_FEB_LEAP  = 5'd29;
    localparam logic [3:0]  M_JAN       = 4'd1;
    localparam logic [3:0]  M_FEB       = 4'd2;
    localparam logic [3:0]  M_DEC       = 4'd12;
    localparam logic [23:0] COUNT_MAX   = 24'h3F_FFFF;

    // Days in month, non-leap; zero for codes that are not months.
    function automatic logic [4:0] f_month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (153 * mm + 2) / 5 with the year starting in March.
    function automatic logic [8:0] f_month_off(input logic [3:0] m);
        logic [8:0] off;
        unique case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== src/dbd_mau.sv =====
// ----------------------------------------------------------------------------
// dbd_mau - shared multiply-accumulate unit
// Registered 15x13 product; accumulator adds or subtracts last product + addend.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_mau (
    input  wire logic               i_clk,
    input  wire logic [14:0]        i_op_a,
    input  wire logic [12:0]        i_op_b,
    input  wire logic [15:0]        i_add,
    input  wire logic               i_clr,
    input  wire logic               i_acc_en,
    input  wire logic               i_sub,
    output logic      [27:0]        o_prod,
    output logic signed [23:0]      o_acc
);

    logic        [27:0] r_prod;
    logic        [27:0] n_prod;
    logic signed [23:0] r_acc;
    logic signed [23:0] n_acc;
    logic signed [23:0] term;

    always_comb begin
        n_prod = 28'(i_op_a) * 28'(i_op_b);
        term   = signed'({1'b0, r_prod[22:0]} + 24'(i_add));
        if (i_clr) begin
            n_acc = '0;
        end else if (i_acc_en) begin
            n_acc = i_sub ? (r_acc - term) : (r_acc + term);
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

// ===== src/dbd_seq.sv =====
// ----------------------------------------------------------------------------
// dbd_seq - step sequencer
// Walks the start date, then the end date, through the shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_seq (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    output dbd_pkg::t_ctl o_ctl
);

    dbd_pkg::t_state r_state;
    dbd_pkg::t_state n_state;
    logic            r_end;
    logic            n_end;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbd_pkg::ST_IDLE;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_end   <= n_end;
        end
    end

    always_comb begin
        n_state = r_state;
        n_end   = r_end;
        accept  = 1'b0;
        unique case (r_state)
            dbd_pkg::ST_IDLE: begin
                if (i_start) begin
                    accept  = 1'b1;
                    n_end   = 1'b0;
                    n_state = dbd_pkg::ST_MUL_Y;
                end
            end
            dbd_pkg::ST_MUL_Y: n_state = dbd_pkg::ST_MUL_Q;
            dbd_pkg::ST_MUL_Q: n_state = dbd_pkg::ST_MUL_A;
            dbd_pkg::ST_MUL_A: n_state = dbd_pkg::ST_MUL_D;
            dbd_pkg::ST_MUL_D: n_state = dbd_pkg::ST_ACC;
            dbd_pkg::ST_ACC: begin
                if (r_end) begin
                    n_state = dbd_pkg::ST_FIN;
                end else begin
                    n_end   = 1'b1;
                    n_state = dbd_pkg::ST_MUL_Y;
                end
            end
            dbd_pkg::ST_FIN: n_state = dbd_pkg::ST_IDLE;
            default:         n_state = dbd_pkg::ST_IDLE;
        endcase
        o_ctl.state   = r_state;
        o_ctl.use_end = r_end;
        o_ctl.accept  = accept;
    end

endmodule

`default_nettype wire

// ===== src/days_between_dates.sv =====
// ----------------------------------------------------------------------------
// days_between_dates - Gregorian day count between two dates
// Closed-form day numbers of both dates on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 word
//  -------   -----------------------   ------------------------------------------
//  command   start / busy              i_start_* , i_end_* (day, month, year)
//  result    o_done (1-cycle strobe)   o_day_count, o_invalid_date
//  config    i_cfg_valid/o_cfg_ready   i_cfg_data -> include_end_day
//
//  Busy stays high from the accept edge through 4 products and 1 accumulate
//    per date on the single shared multiplier, then the clamp step (FIN);
//    the result strobe is registered from FIN.
//  busy drops in the strobe cycle, so the next word may go in right then.
//  Reset (i_rst_n low, synchronous): sequencer idle, include_end_day = 1.
//  The receiver cannot stall: o_done shows for one cycle only.
//
//  Day number per date: a = y + 400 (less 1 for Jan/Feb),
//    N = 365a + a/4 - a/100 + a/400 + month offset + d.
//  Divide by 100 is a reciprocal multiply; a/400 is (a/100)/4.
//  The accumulator collects N(end) - N(start) directly.
//  Leap: y%4 == 0 and (y%100 != 0 or (y/100)%4 == 0).
//
`default_nettype none

module days_between_dates (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command
    input  wire logic        start,
    output logic             busy,
    input  wire logic [4:0]  i_start_day,
    input  wire logic [3:0]  i_start_month,
    input  wire logic [13:0] i_start_year,
    input  wire logic [4:0]  i_end_day,
    input  wire logic [3:0]  i_end_month,
    input  wire logic [13:0] i_end_year,
    // result
    output logic             o_done,
    output logic [21:0]      o_day_count,
    output logic             o_invalid_date,
    // config
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

    dbd_pkg::t_ctl ctl;

    // captured word
    logic [4:0]  r_sd, r_ed;
    logic [3:0]  r_sm, r_em;
    logic [13:0] r_sy, r_ey;

    // per-date scratch
    logic [8:0]  r_qy, n_qy;      // y / 100
    logic [8:0]  r_qa, n_qa;      // a / 100
    logic        r_bad, n_bad;

    // result and config
    logic        r_inc;
    logic        r_done, n_done;
    logic [21:0] r_count, n_count;
    logic        r_invalid, n_invalid;

    // unit hookup
    logic [14:0]        op_a;
    logic [12:0]        op_b;
    logic [15:0]        add;
    logic               acc_en;
    logic [27:0]        prod;
    logic signed [23:0] acc;

    // current date
    logic [4:0]  cur_d;
    logic [3:0]  cur_m;
    logic [13:0] cur_y;
    logic        early;           // Jan or Feb: counts in previous year
    logic [14:0] a_val;
    logic        leap;
    logic [4:0]  mlen;
    logic        date_ok;
    logic [8:0]  q_prod;
    logic [22:0] base;
    logic [23:0] total;

    dbd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_ctl   (ctl)
    );

    dbd_mau u_mau (
        .i_clk    (i_clk),
        .i_op_a   (op_a),
        .i_op_b   (op_b),
        .i_add    (add),
        .i_clr    (ctl.accept),
        .i_acc_en (acc_en),
        .i_sub    (~ctl.use_end),
        .o_prod   (prod),
        .o_acc    (acc)
    );

    assign busy        = (ctl.state != dbd_pkg::ST_IDLE);
    assign o_cfg_ready = ~busy;

    always_comb begin
        cur_d  = ctl.use_end ? r_ed : r_sd;
        cur_m  = ctl.use_end ? r_em : r_sm;
        cur_y  = ctl.use_end ? r_ey : r_sy;
        early  = (cur_m <= dbd_pkg::M_FEB);
        a_val  = 15'(cur_y) + dbd_pkg::K_EPOCH - 15'(early);
        q_prod = prod[dbd_pkg::RECIP_SHIFT +: 9];

        // prod holds (y/100)*100 during MUL_A
        leap = (cur_y[1:0] == 2'b00)
            && ((prod != 28'(cur_y)) || (r_qy[1:0] == 2'b00));
        mlen = (cur_m == dbd_pkg::M_FEB && leap) ? dbd_pkg::K_FEB_LEAP
                                                 : dbd_pkg::f_month_len(cur_m);
        date_ok = (cur_m >= dbd_pkg::M_JAN) && (cur_m <= dbd_pkg::M_DEC)
               && (cur_d != 5'd0) && (cur_d <= mlen);

        // a/4 - a/100 + a/400 + month offset + d, never negative
        add = 16'(a_val[14:2]) - 16'(r_qa) + 16'(r_qa[8:2])
            + 16'(dbd_pkg::f_month_off(cur_m)) + 16'(cur_d);

        op_a   = '0;
        op_b   = '0;
        acc_en = 1'b0;
        n_qy   = r_qy;
        n_qa   = r_qa;
        n_bad  = r_bad;
        unique case (ctl.state)
            dbd_pkg::ST_IDLE: begin
                if (ctl.accept) begin
                    n_bad = 1'b0;
                end
            end
            dbd_pkg::ST_MUL_Y: begin
                op_a = 15'(cur_y);
                op_b = dbd_pkg::K_RECIP100;
            end
            dbd_pkg::ST_MUL_Q: begin
                n_qy = q_prod;
                op_a = 15'(q_prod);
                op_b = dbd_pkg::K_HUNDRED;
            end
            dbd_pkg::ST_MUL_A: begin
                n_bad = r_bad | ~date_ok;
                op_a  = a_val;
                op_b  = dbd_pkg::K_RECIP100;
            end
            dbd_pkg::ST_MUL_D: begin
                n_qa = q_prod;
                op_a = a_val;
                op_b = dbd_pkg::K_YEAR_DAYS;
            end
            dbd_pkg::ST_ACC: begin
                acc_en = 1'b1;
            end
            dbd_pkg::ST_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // Clamp: negative difference is zero, end day added, saturate to 22 bits.
    always_comb begin
        base      = acc[23] ? '0 : acc[22:0];
        total     = {1'b0, base} + 24'(r_inc);
        n_done    = (ctl.state == dbd_pkg::ST_FIN);
        n_invalid = r_invalid;
        n_count   = r_count;
        if (n_done) begin
            n_invalid = r_bad;
            if (r_bad) begin
                n_count = '0;
            end else if (total > dbd_pkg::COUNT_MAX) begin
                n_count = dbd_pkg::COUNT_MAX[21:0];
            end else begin
                n_count = total[21:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc  <= 1'b1;
            r_done <= 1'b0;
            r_bad  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_inc <= i_cfg_data;
            end
            r_done <= n_done;
            r_bad  <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.accept) begin
            r_sd <= i_start_day;
            r_sm <= i_start_month;
            r_sy <= i_start_year;
            r_ed <= i_end_day;
            r_em <= i_end_month;
            r_ey <= i_end_year;
        end
        r_qy      <= n_qy;
        r_qa      <= n_qa;
        r_count   <= n_count;
        r_invalid <= n_invalid;
    end

    assign o_done         = r_done;
    assign o_day_count    = r_count;
    assign o_invalid_date = r_invalid;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_done)
        else $error("accepted word did not start the sequencer");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_invalid_date |-> o_day_count == '0)
        else $error("invalid date with nonzero count");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for days_between_dates
// Walks a short table of calendar corner cases, then random date pairs in
// bursts. Each result word is checked against a typed-in value or an in-bench
// day-number predictor; random pairs run under both include_end_day settings.
// ----------------------------------------------------------------------------

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [21:0] DAY_COUNT_MAX  = 22'h3F_FFFF;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam int          RANDOM_WORDS   = 1880;
    localparam int          RANDOM_PHASES  = 4;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int          WATCHDOG_LIMIT = 400;  // idle cycles before the run is abandoned

    // One expected result word.
    typedef struct packed {
        logic [21:0] day_count;
        logic        invalid_date;
    } t_span;

    // One row of the directed table. known = 1: the expected word is typed in,
    // else the predictor supplies it.
    typedef struct packed {
        logic [4:0]  sd;
        logic [3:0]  sm;
        logic [13:0] sy;
        logic [4:0]  ed;
        logic [3:0]  em;
        logic [13:0] ey;
        logic        known;
        logic [21:0] exp_count;
        logic        exp_invalid;
    } t_date_row;

    localparam int NUM_ROWS = 23;

    // Reset value of include_end_day is 1, so typed counts below include the
    // end day.
    localparam t_date_row DATE_ROWS [NUM_ROWS] = '{
        // same date: base count zero, end day adds one
        '{5'd1,  4'd1,  14'd2000,  5'd1,  4'd1,  14'd2000,  1'b1, 22'd1, 1'b0},
        // start after end
        '{5'd1,  4'd1,  14'd2024,  5'd31, 4'd12, 14'd2023,  1'b1, 22'd1, 1'b0},
        '{5'd15, 4'd6,  14'd9999,  5'd15, 4'd6,  14'd1,     1'b1, 22'd1, 1'b0},
        // bad days and months on either side
        '{5'd0,  4'd1,  14'd2000,  5'd1,  4'd1,  14'd2001,  1'b1, 22'd0, 1'b1},
        '{5'd1,  4'd1,  14'd2000,  5'd0,  4'd1,  14'd2001,  1'b1, 22'd0, 1'b1},
        '{5'd1,  4'd0,  14'd2000,  5'd1,  4'd1,  14'd2001,  1'b1, 22'd0, 1'b1},
        '{5'd1,  4'd1,  14'd2000,  5'd1,  4'd13, 14'd2001,  1'b1, 22'd0, 1'b1},
        '{5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383, 1'b1, 22'd0, 1'b1},
        '{5'd0,  4'd0,  14'd0,     5'd0,  4'd0,  14'd0,     1'b1, 22'd0, 1'b1},
        '{5'd31, 4'd4,  14'd2021,  5'd1,  4'd5,  14'd2021,  1'b1, 22'd0, 1'b1},
        // Feb 29 in century years that are not leap, Feb 30
        '{5'd29, 4'd2,  14'd1900,  5'd1,  4'd3,  14'd1900,  1'b1, 22'd0, 1'b1},
        '{5'd1,  4'd1,  14'd2100,  5'd29, 4'd2,  14'd2100,  1'b1, 22'd0, 1'b1},
        '{5'd30, 4'd2,  14'd2000,  5'd1,  4'd3,  14'd2000,  1'b1, 22'd0, 1'b1},
        // leap days that exist, and Feb 28 in a common year
        '{5'd29, 4'd2,  14'd2000,  5'd1,  4'd3,  14'd2000,  1'b0, 22'd0, 1'b0},
        '{5'd29, 4'd2,  14'd2024,  5'd29, 4'd2,  14'd2028,  1'b0, 22'd0, 1'b0},
        '{5'd28, 4'd2,  14'd2023,  5'd1,  4'd3,  14'd2023,  1'b0, 22'd0, 1'b0},
        '{5'd29, 4'd2,  14'd0,     5'd1,  4'd3,  14'd0,     1'b0, 22'd0, 1'b0},
        // year boundaries and the full calendar span
        '{5'd31, 4'd12, 14'd1999,  5'd1,  4'd1,  14'd2000,  1'b0, 22'd0, 1'b0},
        '{5'd31, 4'd1,  14'd2001,  5'd31, 4'd12, 14'd2001,  1'b0, 22'd0, 1'b0},
        '{5'd1,  4'd1,  14'd0,     5'd31, 4'd12, 14'd9999,  1'b0, 22'd0, 1'b0},
        '{5'd1,  4'd1,  14'd1,     5'd31, 4'd12, 14'd9999,  1'b0, 22'd0, 1'b0},
        // years past 9999 are taken as is; the widest span saturates
        '{5'd1,  4'd1,  14'd16383, 5'd31, 4'd12, 14'd16383, 1'b0, 22'd0, 1'b0},
        '{5'd1,  4'd1,  14'd0,     5'd31, 4'd12, 14'd16383, 1'b1, DAY_COUNT_MAX, 1'b0}
    };

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [4:0]  i_start_day;
    logic [3:0]  i_start_month;
    logic [13:0] i_start_year;
    logic [4:0]  i_end_day;
    logic [3:0]  i_end_month;
    logic [13:0] i_end_year;
    logic        o_done;
    logic [21:0] o_day_count;
    logic        o_invalid_date;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    // Travel alongside the word: a typed-in expectation for table rows.
    logic        word_known;
    t_span       word_exp;

    days_between_dates u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_end_day      (i_end_day),
        .i_end_month    (i_end_month),
        .i_end_year     (i_end_year),
        .o_done         (o_done),
        .o_day_count    (o_day_count),
        .o_invalid_date (o_invalid_date),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------
    logic  end_day_incl;      // bench copy of include_end_day
    t_span expected_spans[$]; // words accepted, result not yet seen
    bit    mismatch_seen;
    int    idle_cycles;

    // Proleptic Gregorian: year 0 counts as leap.
    function automatic bit cal_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned cal_days_in_month(input logic [3:0] m,
                                                      input int unsigned y);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
            4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
            MONTH_FEB:                                  return cal_leap(y) ? 29 : 28;
            default:                                    return 0;
        endcase
    endfunction

    function automatic bit cal_date_ok(input logic [4:0] d, input logic [3:0] m,
                                       input logic [13:0] y);
        return (d != 5'd0) && (d <= cal_days_in_month(m, y));
    endfunction

    // Day number with the year counted from March; the +400 keeps a > 0.
    function automatic longint cal_day_number(input logic [4:0] d, input logic [3:0] m,
                                              input logic [13:0] y);
        longint a;
        longint mm;
        a = longint'(y) + 400;
        if (m <= MONTH_FEB) begin
            a  = a - 1;
            mm = longint'(m) + 9;
        end else begin
            mm = longint'(m) - 3;
        end
        return 365 * a + a / 4 - a / 100 + a / 400 + (153 * mm + 2) / 5 + longint'(d);
    endfunction

    function automatic t_span predict_span(input logic [4:0] sd, input logic [3:0] sm,
                                           input logic [13:0] sy, input logic [4:0] ed,
                                           input logic [3:0] em, input logic [13:0] ey,
                                           input logic incl);
        t_span  r;
        longint ns;
        longint ne;
        longint cnt;
        if (!cal_date_ok(sd, sm, sy) || !cal_date_ok(ed, em, ey)) begin
            r.day_count    = '0;
            r.invalid_date = 1'b1;
            return r;
        end
        ns  = cal_day_number(sd, sm, sy);
        ne  = cal_day_number(ed, em, ey);
        cnt = (ns < ne) ? ne - ns : 0;
        if (incl)
            cnt = cnt + 1;
        if (cnt > longint'(DAY_COUNT_MAX))
            cnt = longint'(DAY_COUNT_MAX);
        r.day_count    = 22'(cnt);
        r.invalid_date = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and watchdog. All sampling at the rising edge sees the
    // values from before the edge, same as the DUT.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_span want;
        bit    word_taken;
        bit    cfg_taken;
        if (!i_rst_n) begin
            end_day_incl = 1'b1;
            idle_cycles  = 0;
        end else begin
            word_taken = start && !busy;
            cfg_taken  = i_cfg_valid && o_cfg_ready;

            // Oldest result first: a word may be taken in the strobe cycle.
            if (o_done) begin
                if (expected_spans.size() == 0) begin
                    $error("result word with nothing expected: day_count %0d invalid_date %0b",
                           o_day_count, o_invalid_date);
                    mismatch_seen = 1'b1;
                end else begin
                    want = expected_spans.pop_front();
                    if (o_day_count !== want.day_count) begin
                        $error("day_count: expected %0d, got %0d", want.day_count, o_day_count);
                        mismatch_seen = 1'b1;
                    end
                    if (o_invalid_date !== want.invalid_date) begin
                        $error("invalid_date: expected %0b, got %0b",
                               want.invalid_date, o_invalid_date);
                        mismatch_seen = 1'b1;
                    end
                end
            end

            if (word_taken) begin
                if (word_known)
                    expected_spans.push_back(word_exp);
                else
                    expected_spans.push_back(predict_span(i_start_day, i_start_month,
                                                          i_start_year, i_end_day,
                                                          i_end_month, i_end_year,
                                                          end_day_incl));
            end

            // Config only changes while idle, so no word in flight sees it.
            if (cfg_taken)
                end_day_incl = i_cfg_data;

            if (o_done || word_taken || cfg_taken)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;

            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Called at a rising edge; they return at the edge where the
    // handshake completed. send_dates leaves start as it was driven; the
    // config writer drops valid before it returns.
    task automatic send_dates(input logic [4:0] sd, input logic [3:0] sm,
                              input logic [13:0] sy, input logic [4:0] ed,
                              input logic [3:0] em, input logic [13:0] ey,
                              input logic known, input t_span exp_word);
        i_start_day   <= sd;
        i_start_month <= sm;
        i_start_year  <= sy;
        i_end_day     <= ed;
        i_end_month   <= em;
        i_end_year    <= ey;
        word_known    <= known;
        word_exp      <= exp_word;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and wait for every outstanding result. Checked on the
    // falling edge so the checker's pops are already done.
    task automatic drain_results();
        start <= 1'b0;
        while (expected_spans.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_end_day_cfg(input logic incl);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= incl;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random dates
    // ------------------------------------------------------------------
    task automatic pick_valid_date(input int unsigned ylo, input int unsigned yhi,
                                   output logic [4:0] d, output logic [3:0] m,
                                   output logic [13:0] y);
        y = 14'($urandom_range(yhi, ylo));
        m = 4'($urandom_range(12, 1));
        d = 5'($urandom_range(cal_days_in_month(m, y), 1));
    endtask

    // Break one date: zero day, month outside 1..12, or a day past month end.
    task automatic spoil_date(inout logic [4:0] d, inout logic [3:0] m,
                              input logic [13:0] y);
        int unsigned len;
        case ($urandom_range(2, 0))
            0: d = 5'd0;
            1: m = 4'($urandom_range(16, 13));   // 16 wraps to month 0
            default: begin
                len = cal_days_in_month(m, y);
                d   = (len < 31) ? 5'($urandom_range(31, len + 1)) : 5'd0;
            end
        endcase
    endtask

    task automatic make_random_dates(output logic [4:0] sd, output logic [3:0] sm,
                                     output logic [13:0] sy, output logic [4:0] ed,
                                     output logic [3:0] em, output logic [13:0] ey);
        int unsigned kind;
        int unsigned ey_near;
        kind = $urandom_range(99, 0);
        pick_valid_date(0, 9999, sd, sm, sy);
        pick_valid_date(0, 9999, ed, em, ey);
        if (kind < 8) begin
            // raw noise over every field bit
            sd = 5'($urandom);
            sm = 4'($urandom);
            sy = 14'($urandom);
            ed = 5'($urandom);
            em = 4'($urandom);
            ey = 14'($urandom);
        end else if (kind < 16) begin
            if ($urandom_range(1, 0))
                spoil_date(sd, sm, sy);
            else
                spoil_date(ed, em, ey);
        end else if (kind < 24) begin
            ed = sd;
            em = sm;
            ey = sy;
        end else if (kind < 34) begin
            pick_valid_date(10000, 16383, sd, sm, sy);
            pick_valid_date(0, 16383, ed, em, ey);
        end else if (kind < 70) begin
            // nearby dates, mostly in order: month and leap-day crossings
            ey_near = sy + $urandom_range(2, 0);
            pick_valid_date(ey_near > 16383 ? 16383 : ey_near,
                            ey_near > 16383 ? 16383 : ey_near, ed, em, ey);
        end
        // otherwise two independent dates, either order
    endtask

    task automatic run_random_bursts(input int words);
        logic [4:0]  sd;
        logic [3:0]  sm;
        logic [13:0] sy;
        logic [4:0]  ed;
        logic [3:0]  em;
        logic [13:0] ey;
        int          left;
        int          burst;
        left = words;
        while (left > 0) begin
            burst = $urandom_range(24, 1);
            for (int k = 0; k < burst && left > 0; k++) begin
                make_random_dates(sd, sm, sy, ed, em, ey);
                send_dates(sd, sm, sy, ed, em, ey, 1'b0, '0);
                left = left - 1;
            end
            // gap length spread across the whole busy window and past it
            start <= 1'b0;
            repeat ($urandom_range(40, 1)) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        t_span row_exp;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_start_day    = '0;
        i_start_month  = '0;
        i_start_year   = '0;
        i_end_day      = '0;
        i_end_month    = '0;
        i_end_year     = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 1'b0;
        word_known     = 1'b0;
        word_exp       = '0;
        mismatch_seen  = 1'b0;
        end_day_incl   = 1'b1;
        idle_cycles    = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, back to back, under the reset config.
        for (int r = 0; r < NUM_ROWS; r++) begin
            row_exp.day_count    = DATE_ROWS[r].exp_count;
            row_exp.invalid_date = DATE_ROWS[r].exp_invalid;
            send_dates(DATE_ROWS[r].sd, DATE_ROWS[r].sm, DATE_ROWS[r].sy,
                       DATE_ROWS[r].ed, DATE_ROWS[r].em, DATE_ROWS[r].ey,
                       DATE_ROWS[r].known, row_exp);
        end

        // Full stop until every result is back, then flip include_end_day
        // each phase: 0, 1, 0, 1.
        drain_results();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_end_day_cfg(p[0]);
            run_random_bursts(RANDOM_WORDS / RANDOM_PHASES);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (expected_spans.size() != 0) begin
            $error("%0d result words never arrived", expected_spans.size());
            mismatch_seen = 1'b1;
        end

        if (!mismatch_seen) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
